// ----- hw/rtl/gre_pkg.sv -----
// package: types, codes and constants shared by the genomic relationship entry block
package gre_pkg;

   // default sizes of the stores and of the fixed point result
   localparam int MAX_INDIVIDUALS_DEF = 256;
   localparam int MAX_LOCI_DEF        = 4096;
   localparam int FRAC_BITS_DEF       = 16;

   // fixed field and register widths
   localparam int INDEX_W   = 8;
   localparam int LOCUS_W   = 12;
   localparam int GENO_W    = 2;
   localparam int SUM_W     = 9;
   localparam int NCFG_W    = 9;
   localparam int LCFG_W    = 13;
   localparam int CSR_DW    = 13;
   localparam int CSR_AW    = 1;
   localparam int REL_W     = 32;
   localparam int STATUS_W  = 2;

   // quotient bits of the scaled division, one below the rounding bit included
   localparam int QUO_W     = 33;
   localparam int DCNT_W    = 6;

   localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
   localparam logic [GENO_W-1:0] GENO_BAD    = 2'd3;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_INDIVIDUAL_COUNT = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_LOCUS_COUNT      = 1'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_GENO = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ZERO_VAR = 2'd3;

   localparam logic [REL_W-1:0] REL_POS_SAT = 32'h7FFF_FFFF;
   localparam logic [REL_W-1:0] REL_NEG_SAT = 32'h8000_0000;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] second_index;
      logic [LOCUS_W-1:0] locus_index;
      logic [GENO_W-1:0]  genotype;
   } req_type;

   typedef struct packed {
      logic signed [REL_W-1:0] relationship;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD_WB,
      S_QUERY,
      S_DRAIN,
      S_DIV_PREP,
      S_DIVIDE,
      S_FINAL
   } state_type;

endpackage

// ----- hw/rtl/genomic_relationship_entry.sv -----
// top level: genotype store, allele sums, relationship walk and scaled divider
//
// A load does one read-modify-write of the allele sum. A query reads one locus of
// both rows per cycle from the genotype memory; a 3 stage multiply-accumulate
// follows, then a 33 step restoring divider forms the rounded Q(FRAC_BITS)
// result. Range and genotype errors answer in the cycle after start. After reset
// the block clears the allele sum memory, with busy high; configuration writes
// are taken meanwhile. Each result shows on rsp_valid for exactly one cycle and
// cannot be held off.
module genomic_relationship_entry #(
   parameter int MAX_INDIVIDUALS = gre_pkg::MAX_INDIVIDUALS_DEF,
   parameter int MAX_LOCI        = gre_pkg::MAX_LOCI_DEF,
   parameter int FRAC_BITS       = gre_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  gre_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output gre_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [gre_pkg::CSR_AW-1:0]  csr_index,
   input  logic [gre_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int IND_AW  = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
   localparam int LOC_AW  = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
   localparam int N_W     = $clog2(MAX_INDIVIDUALS + 1);
   localparam int LCNT_W  = $clog2(MAX_LOCI + 1);
   localparam int TERM_W  = ((N_W > gre_pkg::SUM_W) ? N_W : gre_pkg::SUM_W) + 3;
   localparam int PROD_W  = 2 * TERM_W;
   localparam int ACC_W   = PROD_W + LOC_AW + 1;
   localparam int SAT_W   = ACC_W + 33;
   localparam int SHF_W   = ACC_W + FRAC_BITS + 2;

   // storage
   logic [gre_pkg::GENO_W-1:0] geno_mem [MAX_INDIVIDUALS][MAX_LOCI];
   logic [gre_pkg::SUM_W-1:0]  sum_mem  [MAX_LOCI];

   gre_pkg::state_type state_ff, state_in;

   logic [gre_pkg::NCFG_W-1:0] n_cfg_ff, n_cfg_in;
   logic [gre_pkg::LCFG_W-1:0] l_cfg_ff, l_cfg_in;
   logic [N_W-1:0]             n_eff;
   logic [LCNT_W-1:0]          l_eff;

   logic [IND_AW-1:0]          fi_ff, fi_in, si_ff, si_in;
   logic [LOC_AW-1:0]          loc_ff, loc_in;
   logic [gre_pkg::GENO_W-1:0] gt_ff, gt_in;
   logic [LCNT_W-1:0]          l_ff, l_in;
   logic [LOC_AW-1:0]          clr_ff, clr_in;

   // memory ports
   logic                       gm_we;
   logic [IND_AW-1:0]          gm_wind;
   logic [LOC_AW-1:0]          gm_wloc;
   logic [gre_pkg::GENO_W-1:0] gm_rd_a_ff, gm_rd_b_ff;
   logic                       sm_we;
   logic [LOC_AW-1:0]          sm_waddr, sm_raddr;
   logic [gre_pkg::SUM_W-1:0]  sm_wdata, sm_rd_ff;

   // multiply-accumulate pipeline
   logic                       p1_v_ff, p1_v_in, p2_v_ff, p2_v_in, p3_v_ff, p3_v_in;
   logic signed [TERM_W-1:0]   a_ff, a_in, b_ff, b_in, s_ff, s_in, t_ff, t_in;
   logic signed [PROD_W-1:0]   pab_ff, pab_in, pst_ff, pst_in;
   logic signed [ACC_W-1:0]    num_ff, num_in, den_ff, den_in;

   // divider
   logic [ACC_W-1:0]           rem_ff, rem_in, dsr_ff, dsr_in;
   logic [gre_pkg::QUO_W-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [gre_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic                       neg_ff, neg_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   gre_pkg::rsp_type           rsp_ff, rsp_in;

   // helpers
   logic                       accept;
   logic [ACC_W-1:0]           mag;
   logic [SAT_W-1:0]           sat_lhs, sat_rhs;
   logic [SHF_W-1:0]           mag_shf;
   logic [ACC_W-1:0]           r2;
   logic [gre_pkg::QUO_W:0]    y_inc;
   logic [gre_pkg::QUO_W-1:0]  rounded;
   logic [gre_pkg::SUM_W:0]    sum_next;
   logic [LCNT_W:0]            l_next;

   // effective counts clipped to the store sizes
   always_comb begin
      n_eff = (32'(n_cfg_ff) > MAX_INDIVIDUALS) ? N_W'(MAX_INDIVIDUALS) : N_W'(n_cfg_ff);
      l_eff = (32'(l_cfg_ff) > MAX_LOCI) ? LCNT_W'(MAX_LOCI) : LCNT_W'(l_cfg_ff);
   end

   assign accept    = start && (state_ff == gre_pkg::S_IDLE);
   assign busy      = (state_ff != gre_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // divider datapath pieces
   always_comb begin
      mag     = num_ff[ACC_W-1] ? ACC_W'(-num_ff) : ACC_W'(num_ff);
      sat_lhs = SAT_W'({mag, 1'b0});
      sat_rhs = SAT_W'({den_ff, {(32 - FRAC_BITS){1'b0}}});
      mag_shf = {mag, {(FRAC_BITS + 2){1'b0}}};
      r2      = {rem_ff[ACC_W-2:0], dvd_ff[gre_pkg::QUO_W-1]};
      y_inc   = {1'b0, quo_ff} + (gre_pkg::QUO_W + 1)'(1);
      rounded = y_inc[gre_pkg::QUO_W:1];
      sum_next = {1'b0, sm_rd_ff} + (gre_pkg::SUM_W + 1)'(gt_ff);
      l_next   = {1'b0, l_ff} + (LCNT_W + 1)'(1);
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      n_cfg_in     = n_cfg_ff;
      l_cfg_in     = l_cfg_ff;
      fi_in        = fi_ff;
      si_in        = si_ff;
      loc_in       = loc_ff;
      gt_in        = gt_ff;
      l_in         = l_ff;
      clr_in       = clr_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      gm_we        = 1'b0;
      gm_wind      = IND_AW'(req_data.first_index);
      gm_wloc      = LOC_AW'(req_data.locus_index);
      sm_we        = 1'b0;
      sm_waddr     = loc_ff;
      sm_wdata     = sum_next[gre_pkg::SUM_W] ? gre_pkg::SUM_MAX : sum_next[gre_pkg::SUM_W-1:0];
      sm_raddr     = l_ff[LOC_AW-1:0];
      p1_v_in      = 1'b0;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            gre_pkg::CSR_INDIVIDUAL_COUNT: n_cfg_in = csr_wdata[gre_pkg::NCFG_W-1:0];
            gre_pkg::CSR_LOCUS_COUNT:      l_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      // pipeline stage 1: centred terms from the memory outputs
      a_in = $signed(TERM_W'(n_eff) * TERM_W'(gm_rd_a_ff)) - $signed(TERM_W'(sm_rd_ff));
      b_in = $signed(TERM_W'(n_eff) * TERM_W'(gm_rd_b_ff)) - $signed(TERM_W'(sm_rd_ff));
      s_in = $signed(TERM_W'(sm_rd_ff));
      t_in = $signed(TERM_W'({n_eff, 1'b0})) - $signed(TERM_W'(sm_rd_ff));
      // stage 2: products
      pab_in = a_ff * b_ff;
      pst_in = s_ff * t_ff;
      p2_v_in = p1_v_ff;
      p3_v_in = p2_v_ff;
      // stage 3: accumulate
      if (p3_v_ff) begin
         num_in = num_ff + ACC_W'(pab_ff);
         den_in = den_ff + ACC_W'(pst_ff);
      end

      case (state_ff)
         gre_pkg::S_CLEAR: begin
            sm_we    = 1'b1;
            sm_waddr = clr_ff;
            sm_wdata = '0;
            clr_in   = clr_ff + LOC_AW'(1);
            if (clr_ff == LOC_AW'(MAX_LOCI - 1)) begin
               state_in = gre_pkg::S_IDLE;
            end
         end
         gre_pkg::S_IDLE: begin
            fi_in  = IND_AW'(req_data.first_index);
            si_in  = IND_AW'(req_data.second_index);
            loc_in = LOC_AW'(req_data.locus_index);
            gt_in  = req_data.genotype;
            sm_raddr = LOC_AW'(req_data.locus_index);
            l_in   = '0;
            num_in = '0;
            den_in = '0;
            if (accept) begin
               rsp_in.relationship = '0;
               rsp_in.status       = gre_pkg::STAT_OK;
               if (req_data.kind == gre_pkg::KIND_LOAD) begin
                  if ((32'(req_data.first_index) >= 32'(n_eff)) ||
                      (32'(req_data.locus_index) >= 32'(l_eff))) begin
                     rsp_in.status = gre_pkg::STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                  end else if (req_data.genotype == gre_pkg::GENO_BAD) begin
                     rsp_in.status = gre_pkg::STAT_BAD_GENO;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     gm_we    = 1'b1;
                     state_in = gre_pkg::S_LOAD_WB;
                  end
               end else begin
                  if ((32'(req_data.first_index) >= 32'(n_eff)) ||
                      (32'(req_data.second_index) >= 32'(n_eff))) begin
                     rsp_in.status = gre_pkg::STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                  end else if (l_eff == '0) begin
                     state_in = gre_pkg::S_DIV_PREP;
                  end else begin
                     state_in = gre_pkg::S_QUERY;
                  end
               end
            end
         end
         gre_pkg::S_LOAD_WB: begin
            // allele sum read-modify-write with saturation
            sm_we        = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = gre_pkg::S_IDLE;
         end
         gre_pkg::S_QUERY: begin
            // one locus of both rows per cycle
            p1_v_in = 1'b1;
            l_in    = l_next[LCNT_W-1:0];
            if (l_next == (LCNT_W + 1)'(l_eff)) begin
               state_in = gre_pkg::S_DRAIN;
            end
         end
         gre_pkg::S_DRAIN: begin
            if (!(p1_v_ff || p2_v_ff || p3_v_ff)) begin
               state_in = gre_pkg::S_DIV_PREP;
            end
         end
         gre_pkg::S_DIV_PREP: begin
            neg_in  = num_ff[ACC_W-1];
            dsr_in  = ACC_W'(den_ff);
            rem_in  = ACC_W'(mag >> (31 - FRAC_BITS));
            dvd_in  = mag_shf[gre_pkg::QUO_W-1:0];
            quo_in  = '0;
            dcnt_in = gre_pkg::DCNT_W'(gre_pkg::QUO_W);
            if (den_ff <= 0) begin
               rsp_in.relationship = '0;
               rsp_in.status       = gre_pkg::STAT_ZERO_VAR;
               rsp_valid_in        = 1'b1;
               state_in            = gre_pkg::S_IDLE;
            end else if (sat_lhs >= sat_rhs) begin
               rsp_in.relationship = num_ff[ACC_W-1] ? gre_pkg::REL_NEG_SAT
                                                      : gre_pkg::REL_POS_SAT;
               rsp_in.status       = gre_pkg::STAT_OK;
               rsp_valid_in        = 1'b1;
               state_in            = gre_pkg::S_IDLE;
            end else begin
               state_in = gre_pkg::S_DIVIDE;
            end
         end
         gre_pkg::S_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            dvd_in  = {dvd_ff[gre_pkg::QUO_W-2:0], 1'b0};
            dcnt_in = dcnt_ff - gre_pkg::DCNT_W'(1);
            if (r2 >= dsr_ff) begin
               rem_in = r2 - dsr_ff;
               quo_in = {quo_ff[gre_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = r2;
               quo_in = {quo_ff[gre_pkg::QUO_W-2:0], 1'b0};
            end
            if (dcnt_ff == gre_pkg::DCNT_W'(1)) begin
               state_in = gre_pkg::S_FINAL;
            end
         end
         gre_pkg::S_FINAL: begin
            // round half away from zero, then saturate to 32 bits
            rsp_in.status = gre_pkg::STAT_OK;
            if (neg_ff) begin
               rsp_in.relationship = rounded[gre_pkg::QUO_W-1:31] != '0 ?
                                     gre_pkg::REL_NEG_SAT : -rounded[31:0];
            end else begin
               rsp_in.relationship = rounded[gre_pkg::QUO_W-1:31] != '0 ?
                                     gre_pkg::REL_POS_SAT : rounded[31:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = gre_pkg::S_IDLE;
         end
         default: begin
            state_in = gre_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gre_pkg::S_CLEAR;
         clr_ff       <= '0;
         n_cfg_ff     <= gre_pkg::NCFG_W'(1);
         l_cfg_ff     <= gre_pkg::LCFG_W'(1);
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         n_cfg_ff     <= n_cfg_in;
         l_cfg_ff     <= l_cfg_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         p3_v_ff      <= p3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fi_ff   <= fi_in;
      si_ff   <= si_in;
      loc_ff  <= loc_in;
      gt_ff   <= gt_in;
      l_ff    <= l_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      s_ff    <= s_in;
      t_ff    <= t_in;
      pab_ff  <= pab_in;
      pst_ff  <= pst_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   // genotype memory: one write, two reads
   always_ff @(posedge clock) begin
      if (gm_we) begin
         geno_mem[gm_wind][gm_wloc] <= req_data.genotype;
      end
      gm_rd_a_ff <= geno_mem[fi_ff][l_ff[LOC_AW-1:0]];
      gm_rd_b_ff <= geno_mem[si_ff][l_ff[LOC_AW-1:0]];
   end

   // allele sum memory: one write, one read
   always_ff @(posedge clock) begin
      if (sm_we) begin
         sum_mem[sm_waddr] <= sm_wdata;
      end
      sm_rd_ff <= sum_mem[sm_raddr];
   end

endmodule

// ----- hw/rtl/gre_checker.sv -----
// checker: port level properties of the relationship block, bound to the top level
module gre_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input gre_pkg::rsp_type rsp_data
);

   // an accepted transaction either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // a result only follows work or an accepted transaction
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && !busy)))
      else $error("result without a transaction");

   // error results carry a zero entry
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != gre_pkg::STAT_OK)) |-> (rsp_data.relationship == 0))
      else $error("error result with non-zero entry");

endmodule

bind genomic_relationship_entry gre_checker u_gre_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- verif/genomic_relationship_entry_test.sv -----
// testbench for the genomic relationship entry block: directed and random transactions
module genomic_relationship_entry_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ROWS     = gre_pkg::MAX_INDIVIDUALS_DEF;
   localparam int N_LOCI     = gre_pkg::MAX_LOCI_DEF;
   localparam int IDLE_LIMIT = 20000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   gre_pkg::req_type           req_data;
   logic                       rsp_valid;
   gre_pkg::rsp_type           rsp_data;
   logic                       csr_we;
   logic [gre_pkg::CSR_AW-1:0] csr_index;
   logic [gre_pkg::CSR_DW-1:0] csr_wdata;

   // predictor state
   bit [gre_pkg::GENO_W-1:0] genotype_cell [N_ROWS*N_LOCI];
   bit                       cell_loaded   [N_ROWS*N_LOCI];
   int                       allele_total  [N_LOCI];
   int                       n_setting;
   int                       l_setting;

   gre_pkg::rsp_type expected_entries[$];
   int               error_count;
   int               idle_cycles;

   genomic_relationship_entry DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_rows();
      return (n_setting > N_ROWS) ? N_ROWS : n_setting;
   endfunction

   function automatic int eff_loci();
      return (l_setting > N_LOCI) ? N_LOCI : l_setting;
   endfunction

   // 2*num/den in signed Q16, rounded half away from zero, saturated
   function automatic logic [gre_pkg::REL_W-1:0] scaled_ratio(longint num, longint den);
      longint unsigned mag;
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned res;
      mag = (num < 0) ? -num : num;
      mag = mag << 1;
      if (mag / den >= (64'd1 << (gre_pkg::REL_W - gre_pkg::FRAC_BITS_DEF))) begin
         res = 64'd1 << gre_pkg::REL_W;
      end else begin
         quo = (mag << gre_pkg::FRAC_BITS_DEF) / den;
         rem = (mag << gre_pkg::FRAC_BITS_DEF) % den;
         res = quo + ((2 * rem >= den) ? 1 : 0);
      end
      if (num < 0) begin
         if (res >= 64'h8000_0000) return gre_pkg::REL_NEG_SAT;
         return gre_pkg::REL_W'(-res);
      end
      if (res > 64'h7FFF_FFFF) return gre_pkg::REL_POS_SAT;
      return gre_pkg::REL_W'(res);
   endfunction

   // expected result of one transaction; loads update the stores
   function automatic gre_pkg::rsp_type relationship_of(gre_pkg::req_type item);
      gre_pkg::rsp_type r;
      int      n;
      int      nl;
      longint  num;
      longint  den;
      longint  s;
      longint  a;
      longint  b;
      n  = eff_rows();
      nl = eff_loci();
      r.relationship = '0;
      r.status = gre_pkg::STAT_OK;
      if (item.kind == gre_pkg::KIND_LOAD) begin
         if (item.first_index >= n || item.locus_index >= nl) begin
            r.status = gre_pkg::STAT_RANGE;
         end else if (item.genotype == gre_pkg::GENO_BAD) begin
            r.status = gre_pkg::STAT_BAD_GENO;
         end else begin
            genotype_cell[item.first_index*N_LOCI + item.locus_index] = item.genotype;
            cell_loaded[item.first_index*N_LOCI + item.locus_index] = 1'b1;
            allele_total[item.locus_index] += item.genotype;
            if (allele_total[item.locus_index] > gre_pkg::SUM_MAX)
               allele_total[item.locus_index] = gre_pkg::SUM_MAX;
         end
      end else if (item.first_index >= n || item.second_index >= n) begin
         r.status = gre_pkg::STAT_RANGE;
      end else begin
         num = 0;
         den = 0;
         for (int l = 0; l < nl; l++) begin
            s = allele_total[l];
            a = n * genotype_cell[item.first_index*N_LOCI + l] - s;
            b = n * genotype_cell[item.second_index*N_LOCI + l] - s;
            num += a * b;
            den += s * (2 * n - s);
         end
         if (den <= 0) r.status = gre_pkg::STAT_ZERO_VAR;
         else r.relationship = scaled_ratio(num, den);
      end
      return r;
   endfunction

   // true when a query of these rows reads only loaded cells
   function automatic bit rows_loaded(int fi, int si);
      for (int l = 0; l < eff_loci(); l++) begin
         if (!cell_loaded[fi*N_LOCI + l] || !cell_loaded[si*N_LOCI + l]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // send one transaction after a random gap and record its expected result
   task automatic send_item(gre_pkg::req_type item);
      int               gap;
      gre_pkg::rsp_type want;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      want = relationship_of(item);
      expected_entries = {expected_entries, want};
   endtask

   function automatic gre_pkg::req_type make_item(bit kind, int fi, int si, int loc, int gt);
      gre_pkg::req_type item;
      item.kind         = kind;
      item.first_index  = gre_pkg::INDEX_W'(fi);
      item.second_index = gre_pkg::INDEX_W'(si);
      item.locus_index  = gre_pkg::LOCUS_W'(loc);
      item.genotype     = gre_pkg::GENO_W'(gt);
      return item;
   endfunction

   // register write once every transaction has completed
   task automatic write_register(logic [gre_pkg::CSR_AW-1:0] idx, int value);
      start <= 1'b0;
      @(posedge clock);
      while (expected_entries.size() != 0 || busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= gre_pkg::CSR_DW'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == gre_pkg::CSR_INDIVIDUAL_COUNT) n_setting = value & 9'h1FF;
      else l_setting = value & 13'h1FFF;
   endtask

   // extremes of the fields, range and genotype errors, empty and zero sizes
   task automatic test_directed();
      send_item(make_item(gre_pkg::KIND_LOAD, 0, 8'hFF, 0, 1));
      send_item(make_item(gre_pkg::KIND_LOAD, 1, 0, 0, 2));
      send_item(make_item(gre_pkg::KIND_LOAD, 0, 0, 0, gre_pkg::GENO_BAD));
      send_item(make_item(gre_pkg::KIND_QUERY, 0, 0, 12'hFFF, 3));
      send_item(make_item(gre_pkg::KIND_QUERY, 0, 1, 0, 0));
      write_register(gre_pkg::CSR_INDIVIDUAL_COUNT, 9'h1FF);
      write_register(gre_pkg::CSR_LOCUS_COUNT, 13'h1FFF);
      send_item(make_item(gre_pkg::KIND_LOAD, 255, 0, 4095, 2));
      send_item(make_item(gre_pkg::KIND_LOAD, 255, 0, 4095, gre_pkg::GENO_BAD));
      send_item(make_item(gre_pkg::KIND_LOAD, 8'hAA, 8'h55, 12'hAAA, 0));
      send_item(make_item(gre_pkg::KIND_LOAD, 8'h55, 8'hAA, 12'h555, 1));
      write_register(gre_pkg::CSR_LOCUS_COUNT, 0);
      send_item(make_item(gre_pkg::KIND_QUERY, 255, 8'hAA, 0, 0));
      send_item(make_item(gre_pkg::KIND_LOAD, 0, 0, 0, 1));
      write_register(gre_pkg::CSR_INDIVIDUAL_COUNT, 0);
      send_item(make_item(gre_pkg::KIND_QUERY, 0, 0, 0, 0));
      send_item(make_item(gre_pkg::KIND_LOAD, 0, 0, 0, 1));
   endtask

   // random small matrices: full grid loaded, then queries, with some noise
   task automatic test_random_matrices();
      int sent;
      int n;
      int nl;
      int fi;
      int si;
      gre_pkg::req_type item;
      sent = 0;
      while (sent < 95) begin
         n  = $urandom_range(2, 6);
         nl = $urandom_range(1, 8);
         write_register(gre_pkg::CSR_INDIVIDUAL_COUNT, n);
         write_register(gre_pkg::CSR_LOCUS_COUNT, nl);
         for (int i = 0; i < n; i++) begin
            for (int l = 0; l < nl; l++) begin
               send_item(make_item(gre_pkg::KIND_LOAD, i, $urandom_range(0, 255), l,
                                   $urandom_range(0, 2)));
               sent++;
               if ($urandom_range(0, 9) == 0) begin
                  item = make_item(gre_pkg::KIND_LOAD, $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 4095),
                                   $urandom_range(0, 3));
                  if (item.first_index < n && item.locus_index < nl)
                     item.genotype = gre_pkg::GENO_BAD;
                  send_item(item);
                  sent++;
               end
            end
         end
         repeat ($urandom_range(3, 8)) begin
            fi = $urandom_range(0, n - 1);
            si = $urandom_range(0, n - 1);
            if ($urandom_range(0, 5) == 0) si = $urandom_range(n, 255);
            item = make_item(gre_pkg::KIND_QUERY, fi, si, $urandom_range(0, 4095),
                             $urandom_range(0, 3));
            if (si < n && !rows_loaded(fi, si)) item.second_index = 8'hFF;
            send_item(item);
            sent++;
         end
      end
   endtask

   // large allele sums, then a negative variance after lowering n
   task automatic test_sum_saturation();
      write_register(gre_pkg::CSR_INDIVIDUAL_COUNT, 8);
      write_register(gre_pkg::CSR_LOCUS_COUNT, 1);
      for (int i = 0; i < 8; i++) send_item(make_item(gre_pkg::KIND_LOAD, i, 0, 0, 2));
      send_item(make_item(gre_pkg::KIND_QUERY, 0, 7, 0, 0));
      write_register(gre_pkg::CSR_INDIVIDUAL_COUNT, 2);
      send_item(make_item(gre_pkg::KIND_QUERY, 0, 1, 0, 0));
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      gre_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_entries.size() == 0) begin
            $display("%0t: unexpected result rel=%0d status=%0d", $time,
                     rsp_data.relationship, rsp_data.status);
            error_count++;
         end else begin
            want = expected_entries.pop_front();
            if (rsp_data.relationship !== want.relationship) begin
               $display("%0t: relationship expected %0d actual %0d", $time,
                        want.relationship, rsp_data.relationship);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL genomic_relationship_entry");
         $finish;
      end
   end

   // test sequence
   initial begin
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      reset       = 1'b1;
      error_count = 0;
      idle_cycles = 0;
      n_setting   = 1;
      l_setting   = 1;
      foreach (allele_total[l]) allele_total[l] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_matrices();
      test_sum_saturation();
      start <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("PASS genomic_relationship_entry");
      end else begin
         $display("FAIL genomic_relationship_entry");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/gre_pkg.sv
hw/rtl/genomic_relationship_entry.sv
hw/rtl/gre_checker.sv
verif/genomic_relationship_entry_test.sv
